// File: rtl/core/scfd_pkg.sv
`timescale 1ns / 1ps

package scfd_pkg;

   typedef logic [4:0] pos_type;
   typedef logic [7:0] byte_type;

   localparam logic [31:0] SYNC_WORD     = 32'h55AA_9912;
   localparam byte_type    SYNC_TAIL_SUM = 8'hAB;
   localparam int          PAYLOAD_BYTES = 22;

   localparam pos_type POS_HUNT  = 5'd0;
   localparam pos_type POS_FIRST = 5'd4;
   localparam pos_type POS_CHECK = 5'd26;
   localparam pos_type POS_END   = 5'd27;

   typedef struct packed {
      logic [31:0] pulse_seconds;
      logic [31:0] pulse_nanoseconds;
      byte_type    year_in_century;
      byte_type    month_byte;
      byte_type    day_byte;
      byte_type    hour_byte;
      byte_type    minute_byte;
      byte_type    second_byte;
      logic [31:0] frame_seconds;
      logic [31:0] frame_nanoseconds;
   } result_type;

   typedef struct packed {
      logic at_check;
      logic good;
   } status_type;

endpackage

// File: rtl/core/scfd_if.sv
`timescale 1ns / 1ps

interface scfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface scfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] pulse_seconds;
   logic [31:0] pulse_nanoseconds;
   logic [7:0]  year_in_century;
   logic [7:0]  month_byte;
   logic [7:0]  day_byte;
   logic [7:0]  hour_byte;
   logic [7:0]  minute_byte;
   logic [7:0]  second_byte;
   logic [31:0] frame_seconds;
   logic [31:0] frame_nanoseconds;

   modport source (
      output valid, input ready,
      output pulse_seconds, output pulse_nanoseconds,
      output year_in_century, output month_byte, output day_byte,
      output hour_byte, output minute_byte, output second_byte,
      output frame_seconds, output frame_nanoseconds
   );
   modport sink (
      input valid, output ready,
      input pulse_seconds, input pulse_nanoseconds,
      input year_in_century, input month_byte, input day_byte,
      input hour_byte, input minute_byte, input second_byte,
      input frame_seconds, input frame_nanoseconds
   );
endinterface

// File: rtl/core/scfd_capture.sv
`timescale 1ns / 1ps

module scfd_capture (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 byte_accept,
   input  scfd_pkg::byte_type   data_byte,
   output scfd_pkg::status_type status,
   output scfd_pkg::result_type result
);

   logic [31:0]        window_ff;
   logic [31:0]        window_in;
   scfd_pkg::pos_type  pos_ff;
   scfd_pkg::pos_type  pos_in;
   scfd_pkg::byte_type sum_ff;
   scfd_pkg::byte_type sum_in;
   scfd_pkg::byte_type payload_ff [scfd_pkg::PAYLOAD_BYTES];
   scfd_pkg::byte_type payload_in [scfd_pkg::PAYLOAD_BYTES];
   logic               hunting;
   logic [31:0]        window_shift;

   assign hunting      = (pos_ff < scfd_pkg::POS_FIRST) || (pos_ff >= scfd_pkg::POS_END);
   assign window_shift = {window_ff[23:0], data_byte};

   always_comb begin
      window_in  = window_ff;
      pos_in     = pos_ff;
      sum_in     = sum_ff;
      payload_in = payload_ff;
      if (byte_accept) begin
         if (hunting) begin
            window_in = window_shift;
            if (window_shift == scfd_pkg::SYNC_WORD) begin
               pos_in = scfd_pkg::POS_FIRST;
               sum_in = scfd_pkg::SYNC_TAIL_SUM;
            end else begin
               pos_in = scfd_pkg::POS_HUNT;
            end
         end else if (pos_ff < scfd_pkg::POS_CHECK) begin
            for (int i = 0; i < scfd_pkg::PAYLOAD_BYTES - 1; i++) begin
               payload_in[i] = payload_ff[i + 1];
            end
            payload_in[scfd_pkg::PAYLOAD_BYTES - 1] = data_byte;
            sum_in = sum_ff + data_byte;
            pos_in = pos_ff + 5'd1;
         end else begin
            pos_in = scfd_pkg::POS_HUNT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         pos_ff    <= scfd_pkg::POS_HUNT;
         sum_ff    <= '0;
      end else begin
         window_ff <= window_in;
         pos_ff    <= pos_in;
         sum_ff    <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      payload_ff <= payload_in;
   end

   assign status.at_check = (pos_ff == scfd_pkg::POS_CHECK);
   assign status.good     = byte_accept && status.at_check && (data_byte == sum_ff);

   assign result.pulse_seconds     = {payload_ff[0], payload_ff[1], payload_ff[2], payload_ff[3]};
   assign result.pulse_nanoseconds = {payload_ff[4], payload_ff[5], payload_ff[6], payload_ff[7]};
   assign result.year_in_century   = payload_ff[8];
   assign result.month_byte        = payload_ff[9];
   assign result.day_byte          = payload_ff[10];
   assign result.hour_byte         = payload_ff[11];
   assign result.minute_byte       = payload_ff[12];
   assign result.second_byte       = payload_ff[13];
   assign result.frame_seconds     = {payload_ff[14], payload_ff[15], payload_ff[16],
                                      payload_ff[17]};
   assign result.frame_nanoseconds = {payload_ff[18], payload_ff[19], payload_ff[20],
                                      payload_ff[21]};

   a_pos_legal: assert property (@(posedge clock) disable iff (reset)
      (pos_ff == scfd_pkg::POS_HUNT) ||
      ((pos_ff >= scfd_pkg::POS_FIRST) && (pos_ff <= scfd_pkg::POS_CHECK)))
      else $error("frame position left its legal range");

   a_sync_start: assert property (@(posedge clock) disable iff (reset)
      (byte_accept && hunting && (window_shift == scfd_pkg::SYNC_WORD)) |=>
      ((pos_ff == scfd_pkg::POS_FIRST) && (sum_ff == scfd_pkg::SYNC_TAIL_SUM)))
      else $error("sync match did not start a capture");

   a_window_frozen: assert property (@(posedge clock) disable iff (reset)
      !hunting |=> $stable(window_ff))
      else $error("hunt window shifted during capture");

endmodule

// File: rtl/core/sync_checksum_frame_deframer_unit.sv
`timescale 1ns / 1ps
// Latency: a result is valid in the cycle after its checksum byte is accepted.
// Throughput: one byte per cycle; a stalled result only holds back a checksum byte.
// Reset clears the hunt window, frame position, running sum and output valid.
// The payload store is not reset and needs no clearing pass.

module sync_checksum_frame_deframer_unit (
   input  logic              clock,
   input  logic              reset,
   scfd_req_if.sink          req_chan,
   scfd_rsp_if.source        rsp_chan
);

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   scfd_pkg::result_type result_ff;
   scfd_pkg::result_type result_in;
   scfd_pkg::result_type result_next;
   scfd_pkg::status_type status;
   logic                 byte_accept;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready || !status.at_check;
   assign byte_accept    = req_chan.valid && req_chan.ready;

   scfd_capture u_capture (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .data_byte   (req_chan.data_byte),
      .status      (status),
      .result      (result_next)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      result_in    = result_ff;
      if (status.good) begin
         rsp_valid_in = 1'b1;
         result_in    = result_next;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.pulse_seconds     = result_ff.pulse_seconds;
   assign rsp_chan.pulse_nanoseconds = result_ff.pulse_nanoseconds;
   assign rsp_chan.year_in_century   = result_ff.year_in_century;
   assign rsp_chan.month_byte        = result_ff.month_byte;
   assign rsp_chan.day_byte          = result_ff.day_byte;
   assign rsp_chan.hour_byte         = result_ff.hour_byte;
   assign rsp_chan.minute_byte       = result_ff.minute_byte;
   assign rsp_chan.second_byte       = result_ff.second_byte;
   assign rsp_chan.frame_seconds     = result_ff.frame_seconds;
   assign rsp_chan.frame_nanoseconds = result_ff.frame_nanoseconds;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      status.good |-> (!rsp_valid_ff || rsp_chan.ready))
      else $error("good frame would overwrite a waiting result");

   a_good_shows: assert property (@(posedge clock) disable iff (reset)
      status.good |=> rsp_valid_ff)
      else $error("good frame did not raise the result valid");

   a_good_at_check: assert property (@(posedge clock) disable iff (reset)
      status.good |-> (byte_accept && status.at_check))
      else $error("good frame flagged away from the checksum byte");

endmodule

// File: sim/frame_check_pkg.sv
`timescale 1ns / 1ps

package frame_check_pkg;

   import scfd_pkg::*;

   class frame_scoreboard;
      logic [31:0] hunt_bytes;
      pos_type     capture_pos;
      byte_type    captured[PAYLOAD_BYTES];
      byte_type    byte_sum;
      result_type  awaited_frames[$];
      int unsigned mismatches;
      int unsigned frames_checked;

      function new();
         hunt_bytes  = '0;
         capture_pos = POS_HUNT;
         byte_sum    = '0;
         mismatches  = 0;
         frames_checked = 0;
         foreach (captured[k]) captured[k] = '0;
      endfunction

      function void track_byte(byte_type value);
         result_type frame;
         if (capture_pos < POS_FIRST || capture_pos > POS_CHECK) begin
            hunt_bytes = {hunt_bytes[23:0], value};
            if (hunt_bytes == SYNC_WORD) begin
               capture_pos = POS_FIRST;
               byte_sum    = SYNC_TAIL_SUM;
            end else begin
               capture_pos = POS_HUNT;
            end
         end else if (capture_pos < POS_CHECK) begin
            captured[capture_pos - POS_FIRST] = value;
            byte_sum    = byte_sum + value;
            capture_pos = capture_pos + 5'd1;
         end else begin
            capture_pos = POS_HUNT;
            if (value == byte_sum) begin
               frame.pulse_seconds     = {captured[0], captured[1], captured[2], captured[3]};
               frame.pulse_nanoseconds = {captured[4], captured[5], captured[6], captured[7]};
               frame.year_in_century   = captured[8];
               frame.month_byte        = captured[9];
               frame.day_byte          = captured[10];
               frame.hour_byte         = captured[11];
               frame.minute_byte       = captured[12];
               frame.second_byte       = captured[13];
               frame.frame_seconds     = {captured[14], captured[15], captured[16], captured[17]};
               frame.frame_nanoseconds = {captured[18], captured[19], captured[20], captured[21]};
               awaited_frames.push_back(frame);
            end
         end
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] seen);
         if (want !== seen) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, seen);
         end
      endfunction

      function void check_frame(result_type seen);
         result_type want;
         if (awaited_frames.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, actual %h", $time, seen);
            return;
         end
         want = awaited_frames.pop_front();
         frames_checked++;
         compare_field("pulse_seconds", want.pulse_seconds, seen.pulse_seconds);
         compare_field("pulse_nanoseconds", want.pulse_nanoseconds, seen.pulse_nanoseconds);
         compare_field("year_in_century", 32'(want.year_in_century),
                       32'(seen.year_in_century));
         compare_field("month_byte", 32'(want.month_byte), 32'(seen.month_byte));
         compare_field("day_byte", 32'(want.day_byte), 32'(seen.day_byte));
         compare_field("hour_byte", 32'(want.hour_byte), 32'(seen.hour_byte));
         compare_field("minute_byte", 32'(want.minute_byte), 32'(seen.minute_byte));
         compare_field("second_byte", 32'(want.second_byte), 32'(seen.second_byte));
         compare_field("frame_seconds", want.frame_seconds, seen.frame_seconds);
         compare_field("frame_nanoseconds", want.frame_nanoseconds, seen.frame_nanoseconds);
      endfunction

      function void report_missing();
         while (awaited_frames.size() > 0) begin
            mismatches++;
            $display("%0t: missing result, expected %h, actual none",
                     $time, awaited_frames.pop_front());
         end
      endfunction
   endclass

endpackage

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   import scfd_pkg::*;
   import frame_check_pkg::*;

   localparam int TARGET_ITEMS = 1650;

   logic clock;
   logic reset;

   scfd_req_if req_bus ();
   scfd_rsp_if rsp_bus ();

   frame_scoreboard sb;

   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   int unsigned items_sent;
   int unsigned frame_items;
   int unsigned good_frames_sent;
   int unsigned bad_frames_sent;
   int unsigned noise_bursts;

   sync_checksum_frame_deframer_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus.sink),
      .rsp_chan (rsp_bus.source)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // The receiver counts its own cycles and holds off twice for a long stretch.
   initial begin
      int unsigned cycle_count;
      cycle_count = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         cycle_count++;
         if ((cycle_count >= 700 && cycle_count < 1100) ||
             (cycle_count >= 2600 && cycle_count < 2900)) begin
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   initial begin
      result_type seen;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            seen.pulse_seconds     = rsp_bus.pulse_seconds;
            seen.pulse_nanoseconds = rsp_bus.pulse_nanoseconds;
            seen.year_in_century   = rsp_bus.year_in_century;
            seen.month_byte        = rsp_bus.month_byte;
            seen.day_byte          = rsp_bus.day_byte;
            seen.hour_byte         = rsp_bus.hour_byte;
            seen.minute_byte       = rsp_bus.minute_byte;
            seen.second_byte       = rsp_bus.second_byte;
            seen.frame_seconds     = rsp_bus.frame_seconds;
            seen.frame_nanoseconds = rsp_bus.frame_nanoseconds;
            sb.check_frame(seen);
         end
      end
   end

   task automatic send_byte(input byte_type value);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= value;
      do @(posedge clock); while (!req_bus.ready);
      sb.track_byte(value);
      items_sent++;
   endtask

   // Fill style: 0 random, 1 all zero, 2 all ones, 3 a mix of extremes and random bytes.
   task automatic send_frame(input bit good, input int unsigned fill);
      byte_type frame[27];
      byte_type sum;
      frame[0] = 8'h55;
      frame[1] = 8'hAA;
      frame[2] = 8'h99;
      frame[3] = 8'h12;
      sum = SYNC_TAIL_SUM;
      for (int k = 4; k < 26; k++) begin
         case (fill)
            1: frame[k] = 8'h00;
            2: frame[k] = 8'hFF;
            3: frame[k] = ($urandom_range(2) == 0) ? 8'h00 :
                          ($urandom_range(1) == 0) ? 8'hFF : byte_type'($urandom);
            default: frame[k] = byte_type'($urandom);
         endcase
         sum = sum + frame[k];
      end
      frame[26] = good ? sum : sum + byte_type'($urandom_range(1, 255));
      if (good) begin
         good_frames_sent++;
      end else begin
         bad_frames_sent++;
      end
      for (int k = 0; k < 27; k++) begin
         send_byte(frame[k]);
      end
      frame_items += 27;
   endtask

   initial begin
      int unsigned phase;
      int unsigned pick;
      int unsigned burst;
      int unsigned wait_cycles;
      sb = new();
      send_idle_pct    = 0;
      recv_stall_pct   = 0;
      items_sent       = 0;
      frame_items      = 0;
      good_frames_sent = 0;
      bad_frames_sent  = 0;
      noise_bursts     = 0;
      reset = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.data_byte = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_byte(8'hFF);
      send_byte(8'h00);
      send_frame(1'b1, 3);

      while (frame_items < TARGET_ITEMS) begin
         phase = (frame_items * 5) / TARGET_ITEMS;
         case (phase)
            1: begin
               send_idle_pct  = 60;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 60;
            end
            3: begin
               send_idle_pct  = 24;
               recv_stall_pct = 24;
            end
            default: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
         endcase
         pick = $urandom_range(99);
         if (pick < 70) begin
            send_frame(1'b1, ($urandom_range(9) < 7) ? 0 : $urandom_range(1, 3));
         end else if (pick < 82) begin
            send_frame(1'b0, ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0);
         end else begin
            noise_bursts++;
            case ($urandom_range(3))
               0: begin
                  burst = $urandom_range(1, 6);
                  repeat (burst) send_byte(byte_type'($urandom));
               end
               1: begin
                  // A sync word spoilt in its last byte.
                  send_byte(8'h55);
                  send_byte(8'hAA);
                  send_byte(8'h99);
                  send_byte(8'h12 ^ byte_type'($urandom_range(1, 255)));
               end
               2: begin
                  // Partial sync bytes ahead of whatever the next pick sends.
                  send_byte(8'h55);
                  if ($urandom_range(1) == 0) begin
                     send_byte(8'hAA);
                  end
               end
               default: begin
                  burst = $urandom_range(1, 3);
                  repeat (burst) send_byte(($urandom_range(1) == 0) ? 8'h00 : 8'hFF);
               end
            endcase
         end
      end

      @(negedge clock);
      req_bus.valid <= 1'b0;
      wait_cycles = 0;
      while (sb.awaited_frames.size() > 0 && wait_cycles < 5000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (5) @(posedge clock);
      sb.report_missing();

      $display("Sent %0d bytes: %0d good frames, %0d frames with a bad checksum, %0d noise bursts.",
               items_sent, good_frames_sent, bad_frames_sent, noise_bursts);
      $display("Checked %0d results across idle, sender gap, receiver stall and hold-off phases.",
               sb.frames_checked);
      if (sb.mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
